[rtl/sha256_message_hasher_assert.svh]
// assertion macros for the sha-256 message hasher
// used by the top level only
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// implication checked every cycle outside reset
`define SHA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m failed");
`endif

[rtl/sha_pkg.sv]
// types, constants and functions for the sha-256 message hasher
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_final;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } sha_out_t;

  // classified command from front to back
  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_FINAL = 2'd1,
    CMD_BOTH  = 2'd2
  } sha_cmd_t;

  typedef struct packed {
    sha_cmd_t   cmd;
    logic [7:0] data_byte;
  } sha_q_t;

  localparam int QDepth = 4;
  localparam int QAw    = 2;

  localparam logic [255:0] HashInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction
endpackage

[rtl/sha_front.sv]
// front end: classifies words and queues commands for the back end
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            stall,
  input  sha_pkg::sha_in_t data,
  output logic            q_valid,
  input  logic            q_pop,
  output sha_pkg::sha_q_t q_data
);
  import sha_pkg::*;

  sha_q_t         mem [QDepth];
  logic [QAw:0]   count;
  logic [QAw-1:0] wr_ptr;
  logic [QAw-1:0] rd_ptr;
  logic           push;
  sha_q_t         entry;

  // words with neither byte nor final flag are dropped here
  always_comb begin
    entry.data_byte = data.data_byte;
    if (data.has_byte && data.is_final) entry.cmd = CMD_BOTH;
    else if (data.is_final)             entry.cmd = CMD_FINAL;
    else                                entry.cmd = CMD_BYTE;
  end

  assign stall   = (count == (QAw+1)'(QDepth));
  assign push    = valid && !stall && (data.has_byte || data.is_final);
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAw+1)'(push) - (QAw+1)'(q_pop);
    end
  end
endmodule

[rtl/sha_core.sv]
// back end: block assembly, padding, 64-round compression, digest output
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_pop,
  input  sha_pkg::sha_q_t  q_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t       state;
  logic [31:0]  blk [16];
  logic [31:0]  hw [8];
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;
  logic [60:0]  byte_count;
  logic [5:0]   rnd;
  logic         fin_pend;
  logic         second;
  logic [2:0]   oidx;
  // set when the padded block had no room for the length
  logic         pad_overflow;

  logic [5:0]   pos;
  logic [31:0]  t1, t2, s0, s1, wnew;
  logic [63:0]  bits;
  logic [31:0]  w_cur;

  assign pos   = byte_count[5:0];
  assign bits  = {byte_count, 3'b000};
  assign w_cur = blk[0];

  always_comb begin
    s0   = rotr(blk[1], 7) ^ rotr(blk[1], 18) ^ (blk[1] >> 3);
    s1   = rotr(blk[14], 17) ^ rotr(blk[14], 19) ^ (blk[14] >> 10);
    wnew = blk[0] + s0 + blk[9] + s1;
    t1   = vh + (rotr(ve, 6) ^ rotr(ve, 11) ^ rotr(ve, 25)) + ((ve & vf) ^ (~ve & vg))
         + round_k(rnd) + w_cur;
    t2   = (rotr(va, 2) ^ rotr(va, 13) ^ rotr(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_EMIT);
  assign out_data.digest_word = hw[oidx];
  assign out_data.last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      byte_count <= '0;
      rnd        <= '0;
      fin_pend   <= 1'b0;
      second     <= 1'b0;
      oidx       <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= HashInit[255 - 32*i -: 32];
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_data.cmd != CMD_FINAL) begin
              // big-endian byte packing into the current word
              if (pos[1:0] == 2'd0)
                blk[pos[5:2]] <= {q_data.data_byte, 24'd0};
              else
                blk[pos[5:2]] <= blk[pos[5:2]] |
                  (32'(q_data.data_byte) << (5'(3 - pos[1:0]) * 5'd8));
              byte_count <= byte_count + 61'd1;
            end
            fin_pend <= (q_data.cmd != CMD_BYTE);
            if (q_data.cmd != CMD_FINAL && pos == 6'd63) begin
              state <= S_ROUND;
              rnd   <= '0;
              {va, vb, vc, vd, ve, vf, vg, vh} <=
                {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
            end else if (q_data.cmd != CMD_BYTE) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // pad from current position; second block when no room for length
          fin_pend <= 1'b0;
          for (int i = 0; i < 16; i++) begin
            if (i == 32'(pos[5:2]))
              blk[i] <= (pos[1:0] == 2'd0) ? 32'h80000000 :
                        blk[i] | (32'h80 << (5'(3 - pos[1:0]) * 5'd8));
            else if (pos < 6'd56 && i == 14)
              blk[i] <= bits[63:32];
            else if (pos < 6'd56 && i == 15)
              blk[i] <= bits[31:0];
            else if (i > 32'(pos[5:2]))
              blk[i] <= '0;
          end
          second <= (pos < 6'd56);
          state  <= S_ROUND;
          rnd    <= '0;
          {va, vb, vc, vd, ve, vf, vg, vh} <=
            {hw[0], hw[1], hw[2], hw[3], hw[4], hw[5], hw[6], hw[7]};
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) blk[i] <= blk[i+1];
          blk[15] <= wnew;
          {va, vb, vc, vd, ve, vf, vg, vh} <= {t1 + t2, va, vb, vc, vd + t1, ve, vf, vg};
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          hw[0] <= hw[0] + va; hw[1] <= hw[1] + vb;
          hw[2] <= hw[2] + vc; hw[3] <= hw[3] + vd;
          hw[4] <= hw[4] + ve; hw[5] <= hw[5] + vf;
          hw[6] <= hw[6] + vg; hw[7] <= hw[7] + vh;
          if (fin_pend) begin
            state <= S_PAD;
          end else if (second) begin
            state <= S_EMIT;
            oidx  <= '0;
          end else if (pad_overflow) begin
            // overflow pad block: length-only block follows
            state  <= S_ROUND;
            rnd    <= '0;
            second <= 1'b1;
            for (int i = 0; i < 14; i++) blk[i] <= '0;
            blk[14] <= bits[63:32];
            blk[15] <= bits[31:0];
            {va, vb, vc, vd, ve, vf, vg, vh} <=
              {hw[0] + va, hw[1] + vb, hw[2] + vc, hw[3] + vd,
               hw[4] + ve, hw[5] + vf, hw[6] + vg, hw[7] + vh};
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              state      <= S_IDLE;
              second     <= 1'b0;
              byte_count <= '0;
              for (int i = 0; i < 8; i++) hw[i] <= HashInit[255 - 32*i -: 32];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pad_overflow <= 1'b0;
    else if (state == S_PAD) pad_overflow <= (pos >= 6'd56);
    else if (state == S_ADD) pad_overflow <= 1'b0;
  end
endmodule

[rtl/sha256_message_hasher.sv]
// sha-256 message hasher: one message byte per word in, eight digest words out
// each word passes through the queue; a byte word that fills a block starts compression;
// a final word leads to padding and one or two compressed blocks, then eight output words
// the core runs one round per cycle and pops no word while it compresses a block
// synchronous reset returns the hash to its initial value and empties the queue
`timescale 1ns / 1ps
module sha256_message_hasher (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);
  import sha_pkg::*;
`include "sha256_message_hasher_assert.svh"

  logic   q_valid;
  logic   q_pop;
  sha_q_t q_data;

  sha_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .stall(in_stall), .data(in_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

  sha_core u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

  `SHA_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid)
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SHA_ASSERT_IMP(a_no_pop_while_out, out_valid, !q_pop)
endmodule
